@@ rtl/mf33_pkg.sv @@
// Shared types and constants for the 3x3 mean filter.
// No dependencies.
package mf33_pkg;

  localparam int MAX_ROW_BYTES = 4096;
  localparam int MAX_CHANNELS  = 4;
  localparam int WIN_DEPTH     = 2 * MAX_CHANNELS;
  localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
  localparam int WIN_IDX_W     = $clog2(WIN_DEPTH);

  localparam logic [15:0] MEAN_ROUND_BIAS = 16'd5;
  // floor(x / 9) == (x * 7282) >> 16 for every x below 32768
  localparam logic [15:0] DIV9_RECIP      = 16'd7282;

  localparam logic [1:0] CFG_PIXELS   = 2'd0;
  localparam logic [1:0] CFG_ROWS     = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] KIND_ROW0 = 2'd0;  // first row: fill stores only
  localparam logic [1:0] KIND_PIX  = 2'd1;  // pixel that completes a column
  localparam logic [1:0] KIND_DCOL = 2'd2;  // drain over the last row
  localparam logic [1:0] KIND_TAIL = 2'd3;  // drain of the trailing bytes

  typedef struct packed {
    logic [1:0]        kind;
    logic              lt_c;
    logic              eq_cm1;
    logic              ge_2c;
    logic              tail;
    logic              last;
    logic              has_res;
    logic [2:0]        chan;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pix;
  } mf33_ctl_t;

  // total is a sum of three column sums, at most 9 * 255
  function automatic logic [7:0] mean9(input logic [11:0] total);
    logic [12:0] t;
    logic [26:0] p;
    t = {1'b0, total} + 13'(MEAN_ROUND_BIAS);
    p = 27'(t) * 27'(DIV9_RECIP);
    return p[23:16];
  endfunction

endpackage

@@ rtl/mean_filter_3x3_core.sv @@
// 3x3 mean filter core over an interleaved 8-bit raster stream.
// Stage-1 register (with row-store read), then output register; 1 beat/cycle
// unless stalled, bounded by the row stores' single read/write port pair.
// Reset: synchronous active-low; counters, window and config return to
// defaults. Row stores are not cleared.
module mean_filter_3x3_core
  import mf33_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_pixel_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_mean_value,
  output logic        out_end_of_row,
  output logic        out_end_of_image
);

  logic [10:0] ppr_r;
  logic [12:0] rows_r;
  logic [2:0]  chan_r;
  logic [11:0] col_r, col_nxt;
  logic [12:0] row_r, row_nxt;
  logic [12:0] dcol_r, dcol_nxt;
  logic        s1_v_r;
  mf33_ctl_t   s1_r, ctl_nxt;
  logic        take;
  logic        out_v_r;
  logic [7:0]  out_mean_r;
  logic        out_eor_r, out_eoi_r;

  logic [2:0]  c;
  logic [10:0] p;
  logic [12:0] s;
  logic [12:0] h;
  logic [12:0] pos;
  logic [12:0] k;
  logic        fire;
  logic        accept;
  logic [7:0]  rd_prev, rd_old;
  logic [9:0]  col_sum;
  logic [7:0]  mean_w;
  logic        eor_w, eoi_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r  <= 11'd640;
      rows_r <= 13'd480;
      chan_r <= 3'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PIXELS:   ppr_r  <= cfg_data[10:0];
        CFG_ROWS:     rows_r <= cfg_data;
        CFG_CHANNELS: chan_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamp registers into range
  always_comb begin
    c = chan_r;
    if (c < 3'd1) c = 3'd1;
    if (c > 3'd4) c = 3'd4;
    p = ppr_r;
    if (p < 11'd2) p = 11'd2;
    if (p > 11'd1024) p = 11'd1024;
    unique case (c)
      3'd1:    s = {2'b0, p};
      3'd2:    s = {1'b0, p, 1'b0};
      3'd3:    s = {1'b0, p, 1'b0} + {2'b0, p};
      default: s = {p, 2'b0};
    endcase
    if (s > 13'd4096) s = 13'd4096;
    h = rows_r;
    if (h < 13'd2) h = 13'd2;
    if (h > 13'd4096) h = 13'd4096;
  end

  assign fire     = s1_v_r && (!s1_r.has_res || !out_v_r || out_ready);
  assign in_ready = !s1_v_r || fire;
  assign accept   = in_valid && in_ready;

  // classify the beat and advance the position counters
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    dcol_nxt = dcol_r;
    take     = 1'b0;
    k        = dcol_r - s;
    pos      = (in_operation == OP_PIXEL) ? {1'b0, col_r} : dcol_r;
    ctl_nxt.chan    = c;
    ctl_nxt.pix     = in_pixel_byte;
    ctl_nxt.addr    = pos[ADDR_W-1:0];
    ctl_nxt.lt_c    = pos < {10'd0, c};
    ctl_nxt.eq_cm1  = pos == {10'd0, c} - 13'd1;
    ctl_nxt.ge_2c   = pos >= {9'd0, c, 1'b0};
    ctl_nxt.tail    = 1'b1;
    ctl_nxt.last    = k >= {10'd0, c} - 13'd1;
    ctl_nxt.kind    = KIND_TAIL;
    ctl_nxt.has_res = 1'b1;
    if (in_operation == OP_PIXEL) begin
      if (row_r < h) begin
        take = 1'b1;
        if (row_r == 13'd0) begin
          ctl_nxt.kind    = KIND_ROW0;
          ctl_nxt.has_res = 1'b0;
        end else begin
          ctl_nxt.kind    = KIND_PIX;
          ctl_nxt.tail    = row_r >= 13'd2;
          ctl_nxt.has_res = !ctl_nxt.lt_c || ctl_nxt.tail;
        end
        if ({1'b0, col_r} >= s - 13'd1) begin
          col_nxt = '0;
          row_nxt = row_r + 13'd1;
        end else begin
          col_nxt = col_r + 12'd1;
        end
      end
    end else if (row_r >= h) begin
      take = 1'b1;
      if (dcol_r < s) begin
        ctl_nxt.kind = KIND_DCOL;
        dcol_nxt     = dcol_r + 13'd1;
      end else if (ctl_nxt.last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        dcol_nxt = '0;
      end else begin
        dcol_nxt = dcol_r + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      dcol_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        dcol_r <= dcol_nxt;
        s1_v_r <= take;
      end else if (fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && take) s1_r <= ctl_nxt;
  end

  mf33_line_store u_store (
    .clk     (clk),
    .rd_en   (accept && take),
    .rd_addr (ctl_nxt.addr),
    .wr_en   (fire && (s1_r.kind == KIND_ROW0 || s1_r.kind == KIND_PIX)),
    .wr_addr (s1_r.addr),
    .wr_prev (s1_r.pix),
    .wr_old  ((s1_r.kind == KIND_ROW0) ? s1_r.pix : rd_prev),
    .rd_prev (rd_prev),
    .rd_old  (rd_old)
  );

  always_comb begin
    unique case (s1_r.kind)
      KIND_PIX:  col_sum = {2'b0, rd_old} + {2'b0, rd_prev} + {2'b0, s1_r.pix};
      KIND_DCOL: col_sum = {2'b0, rd_old} + {1'b0, rd_prev, 1'b0};
      default:   col_sum = '0;
    endcase
  end

  mf33_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (fire),
    .ctl          (s1_r),
    .col_sum      (col_sum),
    .mean_value   (mean_w),
    .end_of_row   (eor_w),
    .end_of_image (eoi_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && s1_r.has_res) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_r.has_res) begin
      out_mean_r <= mean_w;
      out_eor_r  <= eor_w;
      out_eoi_r  <= eoi_w;
    end
  end

  assign out_valid        = out_v_r;
  assign out_mean_value   = out_mean_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_image = out_eoi_r;

endmodule

@@ rtl/mf33_line_store.sv @@
// Two row stores (previous and older row), registered read.
// Depends on mf33_pkg.
module mf33_line_store
  import mf33_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_prev,
  input  logic [7:0]        wr_old,
  output logic [7:0]        rd_prev,
  output logic [7:0]        rd_old
);

  logic [7:0] prev_mem [MAX_ROW_BYTES];
  logic [7:0] old_mem  [MAX_ROW_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr] <= wr_prev;
      old_mem[wr_addr]  <= wr_old;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_prev <= prev_mem[rd_addr];
      rd_old  <= old_mem[rd_addr];
    end
  end

endmodule

@@ rtl/mf33_window.sv @@
// Column sum window and mean computation for one beat.
// Depends on mf33_pkg.
module mf33_window
  import mf33_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  mf33_ctl_t  ctl,
  input  logic [9:0] col_sum,
  output logic [7:0] mean_value,
  output logic       end_of_row,
  output logic       end_of_image
);

  logic [9:0]           win_r [WIN_DEPTH];
  logic [WIN_IDX_W-1:0] idx_near;
  logic [WIN_IDX_W-1:0] idx_far;
  logic [9:0]           w_near;
  logic [9:0]           w_far;
  logic [11:0]          total;
  logic [9:0]           left;

  assign idx_near = WIN_IDX_W'({1'b0, ctl.chan} - 4'd1);
  assign idx_far  = WIN_IDX_W'({ctl.chan, 1'b0} - 4'd1);
  assign w_near   = win_r[idx_near];
  assign w_far    = win_r[idx_far];
  assign left     = ctl.ge_2c ? w_far : w_near;

  always_comb begin
    if (ctl.kind == KIND_TAIL || ctl.lt_c) begin
      total = {2'b0, w_far} + {1'b0, w_near, 1'b0};
    end else begin
      total = {2'b0, left} + {2'b0, w_near} + {2'b0, col_sum};
    end
  end

  assign mean_value   = mean9(total);
  assign end_of_row   = (ctl.kind == KIND_TAIL) ? ctl.last : (ctl.lt_c & ctl.eq_cm1);
  assign end_of_image = (ctl.kind == KIND_TAIL) & ctl.last;

  // advance the window on every beat but first-row fills
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= '0;
    end else if (step && ctl.kind != KIND_ROW0) begin
      win_r[0] <= (ctl.kind == KIND_TAIL) ? 10'd0 : col_sum;
      for (int i = 1; i < WIN_DEPTH; i++) win_r[i] <= win_r[i-1];
    end
  end

endmodule

@@ tb/mean_filter_3x3_core_test.sv @@
// Self-checking testbench for mean_filter_3x3_core: random and directed images, checked
// against an in-bench line-store/column-sum predictor. Depends on mf33_pkg and the core.
module mean_filter_3x3_core_test;
  import mf33_pkg::*;

  localparam int WD_LIMIT = 20000;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic       op;
    logic [7:0] px;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] mean;
    logic       eor;
    logic       eoi;
  } mean_beat_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_pixel_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_mean_value;
  logic        out_end_of_row;
  logic        out_end_of_image;

  mean_filter_3x3_core dut (.*);

  // predictor state
  logic [7:0]  prev_line [MAX_ROW_BYTES];
  logic [7:0]  old_line  [MAX_ROW_BYTES];
  logic [9:0]  colsum_win [WIN_DEPTH];
  int unsigned col_pos, row_pos, drain_pos;
  logic [10:0] reg_pixels;
  logic [12:0] reg_rows;
  logic [2:0]  reg_chans;

  pix_item_t  pend_q [$];
  mean_beat_t mean_q [$];
  int         mismatches;
  int         src_idle, snk_idle;
  bit         stall_req;
  int         hold_cnt;
  int         wd_cnt;
  bit         cfg_hit;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic int unsigned eff_chans();
    int unsigned c;
    c = reg_chans;
    if (c < 1) c = 1;
    if (c > MAX_CHANNELS) c = MAX_CHANNELS;
    return c;
  endfunction

  function automatic int unsigned eff_row_bytes();
    int unsigned p, s;
    p = reg_pixels;
    if (p < 2) p = 2;
    if (p > 1024) p = 1024;
    s = p * eff_chans();
    if (s > MAX_ROW_BYTES) s = MAX_ROW_BYTES;
    return s;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned h;
    h = reg_rows;
    if (h < 2) h = 2;
    if (h > 4096) h = 4096;
    return h;
  endfunction

  function automatic logic [7:0] round_mean(int unsigned total);
    return 8'((total + 5) / 9);
  endfunction

  function automatic void shift_sum(int unsigned cs);
    for (int i = WIN_DEPTH - 1; i > 0; i--) colsum_win[i] = colsum_win[i-1];
    colsum_win[0] = 10'(cs);
  endfunction

  function automatic void expect_beat(logic [7:0] m, logic eor, logic eoi);
    mean_beat_t e;
    e.mean = m; e.eor = eor; e.eoi = eoi;
    mean_q.push_back(e);
  endfunction

  function automatic logic [7:0] tail_mean(int unsigned c);
    return round_mean(colsum_win[2*c-1] + 2 * colsum_win[c-1]);
  endfunction

  function automatic void column_result(int unsigned j, int unsigned cs, int unsigned c,
                                        bit tail_due);
    int unsigned left;
    if (j < c) begin
      if (tail_due) expect_beat(tail_mean(c), j == c - 1, 1'b0);
    end else begin
      left = (j >= 2*c) ? colsum_win[2*c-1] : colsum_win[c-1];
      expect_beat(round_mean(left + colsum_win[c-1] + cs), 1'b0, 1'b0);
    end
    shift_sum(cs);
  endfunction

  function automatic void filter_step(logic op, logic [7:0] b);
    int unsigned c, s, h, j, cs, k;
    bit last;
    c = eff_chans();
    s = eff_row_bytes();
    h = eff_rows();
    if (op == OP_PIXEL) begin
      if (row_pos >= h) return;
      j = col_pos % MAX_ROW_BYTES;
      if (row_pos == 0) begin
        old_line[j] = b;
        prev_line[j] = b;
      end else begin
        cs = old_line[j] + prev_line[j] + b;
        column_result(j, cs, c, row_pos >= 2);
        old_line[j] = prev_line[j];
        prev_line[j] = b;
      end
      if (col_pos >= s - 1) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
      return;
    end
    if (row_pos < h) return;
    if (drain_pos < s) begin
      j = drain_pos % MAX_ROW_BYTES;
      cs = old_line[j] + 2 * prev_line[j];
      column_result(j, cs, c, 1'b1);
      drain_pos++;
    end else begin
      k = drain_pos - s;
      last = k >= c - 1;
      expect_beat(tail_mean(c), last, last);
      shift_sum(0);
      if (last) begin
        col_pos = 0; row_pos = 0; drain_pos = 0;
      end else begin
        drain_pos++;
      end
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operation <= OP_PIXEL;
      in_pixel_byte <= 8'd0;
    end else begin
      if (in_valid && in_ready) filter_step(in_operation, in_pixel_byte);
      if (!in_valid || in_ready) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          pix_item_t it;
          it = pend_q.pop_front();
          in_operation <= it.op;
          in_pixel_byte <= it.px;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (mean_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: mean=%0d eor=%0b eoi=%0b",
                     out_mean_value, out_end_of_row, out_end_of_image);
        end else begin
          mean_beat_t e;
          e = mean_q.pop_front();
          if (out_mean_value !== e.mean || out_end_of_row !== e.eor ||
              out_end_of_image !== e.eoi) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected mean=%0d eor=%0b eoi=%0b, got mean=%0d eor=%0b eoi=%0b",
                       e.mean, e.eor, e.eoi, out_mean_value, out_end_of_row,
                       out_end_of_image);
          end
        end
      end
      if (stall_req && hold_cnt == 0) begin
        hold_cnt = HOLD_LEN;
        stall_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= snk_idle;
      end
    end
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        wd_cnt <= 0;
      else if (wd_cnt >= WD_LIMIT) begin
        $display("mean_filter_3x3_core test failed");
        $finish;
      end else
        wd_cnt <= wd_cnt + 1;
    end
  end

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || mean_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PIXELS:   reg_pixels = val[10:0];
      CFG_ROWS:     reg_rows = val;
      CFG_CHANNELS: reg_chans = val[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [12:0] pix, logic [12:0] rows, logic [12:0] ch);
    wait_idle();
    write_reg(CFG_PIXELS, pix);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_CHANNELS, ch);
  endtask

  function automatic logic [7:0] pick_byte(int fill);
    case (fill)
      1: return 8'h00;
      2: return 8'hFF;
      default: begin
        case ($urandom_range(7))
          0: return 8'h00;
          1: return 8'hFF;
          default: return 8'($urandom);
        endcase
      end
    endcase
  endfunction

  // queue a whole image plus its drain; noisy adds early drains and stray pixels
  task automatic queue_image(int fill, bit noisy, inout int count);
    int unsigned s, h, c;
    pix_item_t it;
    s = eff_row_bytes(); h = eff_rows(); c = eff_chans();
    for (int r = 0; r < h; r++) begin
      for (int k = 0; k < s; k++) begin
        if (noisy && $urandom_range(39) == 0) begin
          it.op = OP_DRAIN; it.px = 8'($urandom); pend_q.push_back(it);
        end
        it.op = OP_PIXEL; it.px = pick_byte(fill); pend_q.push_back(it);
      end
    end
    if (noisy) begin
      repeat ($urandom_range(3, 1)) begin
        it.op = OP_PIXEL; it.px = 8'($urandom); pend_q.push_back(it);
      end
    end
    for (int k = 0; k < s + c; k++) begin
      it.op = OP_DRAIN; it.px = 8'($urandom); pend_q.push_back(it);
    end
    count += s * h + s + c;
  endtask

  initial begin
    int done_items;
    int phase;
    done_items = 0;
    mismatches = 0;
    src_idle = 18; snk_idle = 77;
    stall_req = 1'b0;
    wd_cnt = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = CFG_PIXELS; cfg_data = '0;
    in_valid = 1'b0; in_operation = OP_PIXEL; in_pixel_byte = '0;
    out_ready = 1'b0;
    reg_pixels = 11'd640; reg_rows = 13'd480; reg_chans = 3'd1;
    col_pos = 0; row_pos = 0; drain_pos = 0;
    for (int i = 0; i < WIN_DEPTH; i++) colsum_win[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: clamped-low geometry, saturated and zero images, noise
    set_geometry(13'd0, 13'd1, 13'd0);
    queue_image(2, 1'b0, done_items);
    queue_image(1, 1'b1, done_items);
    // clamped-high channels; hold the receiver off so the block fills up
    set_geometry(13'd3, 13'd2, 13'd7);
    stall_req = 1'b1;
    queue_image(0, 1'b1, done_items);

    phase = 0;
    while (done_items < 800) begin
      if (done_items < 270) begin
        src_idle = 18; snk_idle = 77;
      end else if (done_items < 540) begin
        src_idle = 77; snk_idle = 18;
      end else begin
        src_idle = 0; snk_idle = 0;
      end
      set_geometry(13'($urandom_range(12, 2)), 13'($urandom_range(6, 2)),
                   13'($urandom_range(4, 1)));
      if (done_items >= 540 && phase[0]) stall_req = 1'b1;
      repeat ($urandom_range(3, 1)) queue_image(0, $urandom_range(3) == 0, done_items);
      phase++;
    end

    while (pend_q.size() != 0 || in_valid || mean_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && mean_q.size() == 0)
      $display("mean_filter_3x3_core test passed");
    else
      $display("mean_filter_3x3_core test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mf33_pkg.sv
rtl/mf33_line_store.sv
rtl/mf33_window.sv
rtl/mean_filter_3x3_core.sv
tb/mean_filter_3x3_core_test.sv
